// File: hdl/tbse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbse_pkg
// Shared types, codes and helpers for the bit-stream string encoder.
// ----------------------------------------------------------------------------
package tbse_pkg;

    // Open run class held between items
    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_SPACE  = 3'd1,
        CLS_DIGIT  = 3'd2,
        CLS_LETTER = 3'd3,
        CLS_EXTN   = 3'd4,
        CLS_EXTW   = 3'd5
    } cls_t;

    // 2-bit class prefixes
    localparam logic [1:0] PFX_SPACE  = 2'd0;
    localparam logic [1:0] PFX_DIGIT  = 2'd1;
    localparam logic [1:0] PFX_LETTER = 2'd2;
    localparam logic [1:0] PFX_EXT    = 2'd3;

    // 3-bit whitespace codes
    localparam logic [2:0] SP_BLANK = 3'd1;
    localparam logic [2:0] SP_LF    = 3'd2;
    localparam logic [2:0] SP_CR    = 3'd3;
    localparam logic [2:0] SP_TAB   = 3'd4;
    localparam logic [2:0] SP_TERM  = 3'd5;

    // Character boundaries
    localparam logic [31:0] CP_BLANK  = 32'd32;
    localparam logic [31:0] CP_LF     = 32'd10;
    localparam logic [31:0] CP_CR     = 32'd13;
    localparam logic [31:0] CP_TAB    = 32'd9;
    localparam logic [31:0] DIGIT_LO  = 32'd43;
    localparam logic [31:0] DIGIT_HI  = 32'd57;
    localparam logic [31:0] DIGIT_OFS = 32'd42;
    localparam logic [31:0] LETTER_LO = 32'd60;
    localparam logic [31:0] LETTER_HI = 32'd122;
    localparam logic [31:0] LETTER_OFS = 32'd59;
    localparam logic [31:0] LIM_8     = 32'h0000_00FF;
    localparam logic [31:0] LIM_16    = 32'h0000_FFFF;
    localparam logic [31:0] LIM_24    = 32'h00FF_FFFF;

    // Field slots of one command, emitted in this order
    localparam int SLOT_CLOSE = 0;
    localparam int SLOT_PFX   = 1;
    localparam int SLOT_FLAG  = 2;
    localparam int SLOT_TAG   = 3;
    localparam int SLOT_BODY  = 4;
    localparam int NUM_SLOTS  = 5;

    // One classified item, handed from front to back
    typedef struct packed {
        logic        close_en;
        cls_t        close_cls;
        logic        pfx_en;
        logic [1:0]  pfx_val;
        logic        flag_en;
        logic        flag_val;
        logic        tag_en;
        logic [1:0]  tag_val;
        logic [1:0]  tag_bits;
        logic [31:0] body_val;
        logic [5:0]  body_bits;
        logic        body_end;
    } cmd_t;

    // Width of the all-zero close code for a run
    function automatic logic [5:0] close_bits(input cls_t cls);
        logic [5:0] bits;
        case (cls)
            CLS_SPACE:  bits = 6'd3;
            CLS_DIGIT:  bits = 6'd4;
            CLS_LETTER: bits = 6'd6;
            CLS_EXTN:   bits = 6'd9;
            CLS_EXTW:   bits = 6'd10;
            default:    bits = 6'd0;
        endcase
        return bits;
    endfunction

endpackage

// File: hdl/tbse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbse_front
// Accepts items, classifies code points, tracks the open run and builds one
// command per item for the back end. Holds the ext_wide register.
// ----------------------------------------------------------------------------
module tbse_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          ext_wide,
    input  logic          item_valid,
    output logic          item_stall,
    input  logic          mode,
    input  logic [31:0]   code_point,
    input  logic          q_full,
    output logic          q_push,
    output tbse_pkg::cmd_t q_cmd
);
    import tbse_pkg::*;

    logic ext_wide_reg;
    cls_t open_reg;
    cls_t open_next;
    cls_t target;
    logic is_end;
    logic change;
    logic can_close;

    // Config register, writes always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_wide_reg <= 1'b0;
            open_reg     <= CLS_NONE;
        end
        else
        begin
            if (cfg_valid)
                ext_wide_reg <= ext_wide;
            if (q_push)
                open_reg <= open_next;
        end
    end

    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;
    assign is_end     = mode || (code_point == 32'd0);

    // Only real runs get a close code
    always_comb
    begin
        case (open_reg)
            CLS_SPACE, CLS_DIGIT, CLS_LETTER, CLS_EXTN, CLS_EXTW: can_close = 1'b1;
            default: can_close = 1'b0;
        endcase
    end

    // Class of the incoming character
    always_comb
    begin
        if (code_point == CP_BLANK || code_point == CP_LF ||
            code_point == CP_CR || code_point == CP_TAB)
            target = CLS_SPACE;
        else if (code_point >= DIGIT_LO && code_point <= DIGIT_HI)
            target = CLS_DIGIT;
        else if (code_point >= LETTER_LO && code_point <= LETTER_HI)
            target = CLS_LETTER;
        else
            target = ext_wide_reg ? CLS_EXTW : CLS_EXTN;
    end

    assign change = (open_reg != target);

    // Command build
    always_comb
    begin
        q_cmd           = '0;
        q_cmd.close_cls = open_reg;
        open_next       = open_reg;
        if (is_end)
        begin
            // close, enter space class, terminator
            q_cmd.close_en  = can_close && (open_reg != CLS_SPACE);
            q_cmd.pfx_en    = (open_reg != CLS_SPACE);
            q_cmd.pfx_val   = PFX_SPACE;
            q_cmd.body_val  = {29'd0, SP_TERM};
            q_cmd.body_bits = 6'd3;
            q_cmd.body_end  = 1'b1;
            open_next       = CLS_NONE;
        end
        else
        begin
            q_cmd.close_en = change && can_close;
            q_cmd.pfx_en   = change;
            open_next      = target;
            case (target)
                CLS_SPACE:
                begin
                    q_cmd.pfx_val   = PFX_SPACE;
                    q_cmd.body_bits = 6'd3;
                    if (code_point == CP_BLANK)
                        q_cmd.body_val = {29'd0, SP_BLANK};
                    else if (code_point == CP_LF)
                        q_cmd.body_val = {29'd0, SP_LF};
                    else if (code_point == CP_CR)
                        q_cmd.body_val = {29'd0, SP_CR};
                    else
                        q_cmd.body_val = {29'd0, SP_TAB};
                end
                CLS_DIGIT:
                begin
                    q_cmd.pfx_val   = PFX_DIGIT;
                    q_cmd.body_val  = code_point - DIGIT_OFS;
                    q_cmd.body_bits = 6'd4;
                end
                CLS_LETTER:
                begin
                    q_cmd.pfx_val   = PFX_LETTER;
                    q_cmd.body_val  = code_point - LETTER_OFS;
                    q_cmd.body_bits = 6'd6;
                end
                CLS_EXTW:
                begin
                    q_cmd.pfx_val  = PFX_EXT;
                    q_cmd.flag_en  = change;
                    q_cmd.flag_val = 1'b1;
                    q_cmd.tag_en   = 1'b1;
                    q_cmd.tag_bits = 2'd2;
                    q_cmd.body_val = code_point;
                    if (code_point <= LIM_8)
                    begin
                        q_cmd.tag_val   = 2'd0;
                        q_cmd.body_bits = 6'd8;
                    end
                    else if (code_point <= LIM_16)
                    begin
                        q_cmd.tag_val   = 2'd1;
                        q_cmd.body_bits = 6'd16;
                    end
                    else if (code_point <= LIM_24)
                    begin
                        q_cmd.tag_val   = 2'd2;
                        q_cmd.body_bits = 6'd24;
                    end
                    else
                    begin
                        q_cmd.tag_val   = 2'd3;
                        q_cmd.body_bits = 6'd32;
                    end
                end
                default:
                begin
                    // narrow extended: 1-bit tag, 8 or 16 bits
                    q_cmd.pfx_val  = PFX_EXT;
                    q_cmd.flag_en  = change;
                    q_cmd.flag_val = 1'b0;
                    q_cmd.tag_en   = 1'b1;
                    q_cmd.tag_bits = 2'd1;
                    if (code_point <= LIM_8)
                    begin
                        q_cmd.tag_val   = 2'd0;
                        q_cmd.body_val  = code_point;
                        q_cmd.body_bits = 6'd8;
                    end
                    else
                    begin
                        q_cmd.tag_val   = 2'd1;
                        q_cmd.body_val  = code_point & LIM_16;
                        q_cmd.body_bits = 6'd16;
                    end
                end
            endcase
        end
    end

endmodule

// File: hdl/tbse_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbse_queue
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module tbse_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tbse_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output tbse_pkg::cmd_t head_cmd
);
    import tbse_pkg::*;

    cmd_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: hdl/tbse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbse_back
// Expands the head command into bit fields, one per cycle unless field_stall
// holds the output, into a registered output beat.
// ----------------------------------------------------------------------------
module tbse_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_not_empty,
    input  tbse_pkg::cmd_t head_cmd,
    output logic           q_pop,
    output logic           field_valid,
    input  logic           field_stall,
    output logic [31:0]    field_value,
    output logic [5:0]     field_bits,
    output logic           last,
    output logic           string_end
);
    import tbse_pkg::*;

    logic [NUM_SLOTS-1:0] done_reg;
    logic [NUM_SLOTS-1:0] done_next;
    logic [NUM_SLOTS-1:0] en_vec;
    logic [NUM_SLOTS-1:0] pending;
    logic [NUM_SLOTS-1:0] sel;
    logic                 emit;
    logic                 fin;
    logic                 out_free;
    logic                 valid_reg;
    logic [31:0]          value_reg;
    logic [5:0]           bits_reg;
    logic                 last_reg;
    logic                 end_reg;
    logic [31:0]          value_next;
    logic [5:0]           bits_next;
    logic                 end_next;

    assign en_vec[SLOT_CLOSE] = head_cmd.close_en;
    assign en_vec[SLOT_PFX]   = head_cmd.pfx_en;
    assign en_vec[SLOT_FLAG]  = head_cmd.flag_en;
    assign en_vec[SLOT_TAG]   = head_cmd.tag_en;
    assign en_vec[SLOT_BODY]  = 1'b1;

    assign pending  = en_vec & ~done_reg;
    assign sel      = pending & (~pending + {{(NUM_SLOTS-1){1'b0}}, 1'b1});
    assign fin      = ((pending & ~sel) == '0);
    assign out_free = !valid_reg || !field_stall;
    assign emit     = q_not_empty && out_free;
    assign q_pop    = emit && fin;

    // Field select
    always_comb
    begin
        value_next = head_cmd.body_val;
        bits_next  = head_cmd.body_bits;
        end_next   = head_cmd.body_end;
        if (sel[SLOT_CLOSE])
        begin
            value_next = 32'd0;
            bits_next  = close_bits(head_cmd.close_cls);
            end_next   = 1'b0;
        end
        else if (sel[SLOT_PFX])
        begin
            value_next = {30'd0, head_cmd.pfx_val};
            bits_next  = 6'd2;
            end_next   = 1'b0;
        end
        else if (sel[SLOT_FLAG])
        begin
            value_next = {31'd0, head_cmd.flag_val};
            bits_next  = 6'd1;
            end_next   = 1'b0;
        end
        else if (sel[SLOT_TAG])
        begin
            value_next = {30'd0, head_cmd.tag_val};
            bits_next  = {4'd0, head_cmd.tag_bits};
            end_next   = 1'b0;
        end
    end

    // Progress through the head command
    always_comb
    begin
        done_next = done_reg;
        if (emit)
            done_next = fin ? '0 : (done_reg | sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (out_free)
                valid_reg <= emit;
        end
    end

    // Output beat payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            value_reg <= value_next;
            bits_reg  <= bits_next;
            last_reg  <= fin;
            end_reg   <= end_next;
        end
    end

    assign field_valid = valid_reg;
    assign field_value = value_reg;
    assign field_bits  = bits_reg;
    assign last        = last_reg;
    assign string_end  = end_reg;

endmodule

// File: hdl/text_bitstream_string_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_bitstream_string_encoder
// Compact string coder: one code point per item in, value/bit-count
// fields out.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  cfg      | cfg_valid / cfg_ready | ext_wide
//  item in  | item_valid/item_stall | mode, code_point
//  field out| field_valid/field_stall| field_value, field_bits, last, string_end
//
// An item produces 1 to 5 fields; the back end emits one field per cycle
// while the queue holds a command and field_stall does not hold the output.
// An accepted item is registered in the command queue, then in the output beat.
// Reset: no run open, ext_wide = 0, queue and output empty.
// item_stall rises when the two-entry command queue is full; field_stall
// holds the output register and, through it, the back end.
// ----------------------------------------------------------------------------
module text_bitstream_string_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        ext_wide,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        mode,
    input  logic [31:0] code_point,
    output logic        field_valid,
    input  logic        field_stall,
    output logic [31:0] field_value,
    output logic [5:0]  field_bits,
    output logic        last,
    output logic        string_end
);
    import tbse_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_not_empty;

    // Classifier
    tbse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .ext_wide   (ext_wide),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .mode       (mode),
        .code_point (code_point),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    // Command queue
    tbse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // Field emitter
    tbse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head_cmd    (head_cmd),
        .q_pop       (q_pop),
        .field_valid (field_valid),
        .field_stall (field_stall),
        .field_value (field_value),
        .field_bits  (field_bits),
        .last        (last),
        .string_end  (string_end)
    );

endmodule

// File: hdl/tbse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbse_checker
// Port-level checks on the encoder output, bound to the top level.
// ----------------------------------------------------------------------------
module tbse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        field_valid,
    input logic        field_stall,
    input logic [31:0] field_value,
    input logic [5:0]  field_bits,
    input logic        last,
    input logic        string_end
);

    // Stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && field_stall |=> field_valid && $stable(field_value)
            && $stable(field_bits) && $stable(last) && $stable(string_end))
        else $error("stalled field beat changed");

    // Bit count in range
    a_bits: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid |-> (field_bits != 6'd0) && (field_bits <= 6'd32))
        else $error("field_bits out of range");

    // No value bits above the count
    a_mask: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && (field_bits < 6'd32) |-> ((field_value >> field_bits) == 32'd0))
        else $error("field_value wider than field_bits");

    // Terminator is the 3-bit code 5 and ends the item
    a_term: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && string_end |-> last && (field_value == 32'd5) && (field_bits == 6'd3))
        else $error("bad terminator beat");

endmodule

bind text_bitstream_string_encoder tbse_checker u_tbse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .field_valid (field_valid),
    .field_stall (field_stall),
    .field_value (field_value),
    .field_bits  (field_bits),
    .last        (last),
    .string_end  (string_end)
);

// File: bench/text_bitstream_string_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_bitstream_string_encoder_tb
// Self-checking bench for the bit-stream string encoder. Directed strings
// hit every class, every whitespace code, the class boundaries and all
// extended value widths. They also cover the width switch inside an open
// extended run and the two kinds of end item. Random strings follow, with
// ext_wide changed between them.
// Each accepted item is run through a local field predictor. Every output
// beat is checked against the oldest predicted field. Both sides idle at
// random, and one phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module text_bitstream_string_encoder_tb;

    import tbse_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_ITEMS = 80;
    localparam int IDLE_PCT     = 37;

    // One predicted output field
    typedef struct {
        logic [31:0] value;
        logic [5:0]  bits;
        logic        last;
        logic        string_end;
    } field_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic        cfg_wide    = 1'b0;
    logic        item_valid  = 1'b0;
    logic        item_stall;
    logic        mode        = 1'b0;
    logic [31:0] code_point  = 32'd0;
    logic        field_valid;
    logic        field_stall = 1'b0;
    logic [31:0] field_value;
    logic [5:0]  field_bits;
    logic        last;
    logic        string_end;

    // Predictor state: open run and the register copy
    cls_t        run_class = CLS_NONE;
    logic        wide_sel  = 1'b0;
    field_t      field_queue[$];

    int          mismatches    = 0;
    int          fields_seen   = 0;
    int          items_sent    = 0;
    int          strings_sent  = 0;
    int          cycle_count   = 0;
    bit          quiet         = 1'b0;
    bit          holding       = 1'b0;
    event        hold_request;

    text_bitstream_string_encoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .ext_wide    (cfg_wide),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .mode        (mode),
        .code_point  (code_point),
        .field_valid (field_valid),
        .field_stall (field_stall),
        .field_value (field_value),
        .field_bits  (field_bits),
        .last        (last),
        .string_end  (string_end)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Field predictor
    // ------------------------------------------------------------------------
    function automatic void push_field(input logic [31:0] value, input logic [5:0] bits,
                                       input logic term);
        field_t f;
        f.value      = value;
        f.bits       = bits;
        f.last       = 1'b0;
        f.string_end = term;
        field_queue.push_back(f);
    endfunction

    // All-zero code that closes the open run
    function automatic void push_close();
        case (run_class)
            CLS_SPACE:  push_field(32'd0, 6'd3, 1'b0);
            CLS_DIGIT:  push_field(32'd0, 6'd4, 1'b0);
            CLS_LETTER: push_field(32'd0, 6'd6, 1'b0);
            CLS_EXTN:   push_field(32'd0, 6'd9, 1'b0);
            CLS_EXTW:   push_field(32'd0, 6'd10, 1'b0);
            default:    ;
        endcase
    endfunction

    function automatic void predict_fields(input logic is_end, input logic [31:0] cp);
        cls_t target;
        if (is_end || cp == 32'd0)
        begin
            if (run_class != CLS_SPACE)
            begin
                push_close();
                push_field({30'd0, PFX_SPACE}, 6'd2, 1'b0);
            end
            push_field({29'd0, SP_TERM}, 6'd3, 1'b1);
            run_class = CLS_NONE;
        end
        else
        begin
            if (cp == CP_BLANK || cp == CP_LF || cp == CP_CR || cp == CP_TAB)
                target = CLS_SPACE;
            else if (cp >= DIGIT_LO && cp <= DIGIT_HI)
                target = CLS_DIGIT;
            else if (cp >= LETTER_LO && cp <= LETTER_HI)
                target = CLS_LETTER;
            else
                target = wide_sel ? CLS_EXTW : CLS_EXTN;

            // class switch: close old run, open new one
            if (run_class != target)
            begin
                push_close();
                case (target)
                    CLS_SPACE:  push_field({30'd0, PFX_SPACE}, 6'd2, 1'b0);
                    CLS_DIGIT:  push_field({30'd0, PFX_DIGIT}, 6'd2, 1'b0);
                    CLS_LETTER: push_field({30'd0, PFX_LETTER}, 6'd2, 1'b0);
                    default:
                    begin
                        push_field({30'd0, PFX_EXT}, 6'd2, 1'b0);
                        push_field({31'd0, wide_sel}, 6'd1, 1'b0);
                    end
                endcase
                run_class = target;
            end

            // character body
            case (target)
                CLS_SPACE:
                begin
                    if (cp == CP_BLANK)   push_field({29'd0, SP_BLANK}, 6'd3, 1'b0);
                    else if (cp == CP_LF) push_field({29'd0, SP_LF}, 6'd3, 1'b0);
                    else if (cp == CP_CR) push_field({29'd0, SP_CR}, 6'd3, 1'b0);
                    else                  push_field({29'd0, SP_TAB}, 6'd3, 1'b0);
                end
                CLS_DIGIT:  push_field(cp - DIGIT_OFS, 6'd4, 1'b0);
                CLS_LETTER: push_field(cp - LETTER_OFS, 6'd6, 1'b0);
                CLS_EXTW:
                begin
                    if (cp <= LIM_8)
                    begin
                        push_field(32'd0, 6'd2, 1'b0);
                        push_field(cp, 6'd8, 1'b0);
                    end
                    else if (cp <= LIM_16)
                    begin
                        push_field(32'd1, 6'd2, 1'b0);
                        push_field(cp, 6'd16, 1'b0);
                    end
                    else if (cp <= LIM_24)
                    begin
                        push_field(32'd2, 6'd2, 1'b0);
                        push_field(cp, 6'd24, 1'b0);
                    end
                    else
                    begin
                        push_field(32'd3, 6'd2, 1'b0);
                        push_field(cp, 6'd32, 1'b0);
                    end
                end
                default:
                begin
                    // narrow: values above 16 bits lose their upper half
                    if (cp <= LIM_8)
                    begin
                        push_field(32'd0, 6'd1, 1'b0);
                        push_field(cp, 6'd8, 1'b0);
                    end
                    else
                    begin
                        push_field(32'd1, 6'd1, 1'b0);
                        push_field(cp & LIM_16, 6'd16, 1'b0);
                    end
                end
            endcase
        end
        field_queue[field_queue.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got 0x%0h, expected 0x%0h (field %0d, cycle %0d)",
                 what, got, want, fields_seen, cycle_count);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        field_t want;
        if (rst_n && field_valid && !field_stall)
        begin
            if (field_queue.size() == 0)
                report_mismatch("unexpected beat", field_value, 32'd0);
            else
            begin
                want = field_queue.pop_front();
                if (field_value !== want.value)
                    report_mismatch("field_value", field_value, want.value);
                if (field_bits !== want.bits)
                    report_mismatch("field_bits", {26'd0, field_bits}, {26'd0, want.bits});
                if (last !== want.last)
                    report_mismatch("last", {31'd0, last}, {31'd0, want.last});
                if (string_end !== want.string_end)
                    report_mismatch("string_end", {31'd0, string_end},
                                    {31'd0, want.string_end});
            end
            fields_seen++;
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d fields pending", cycle_count,
                     field_queue.size());
            $display("[text_bitstream_string_encoder] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall, quiet stretches, long hold on request
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            field_stall <= 1'b0;
        else if (holding)
            field_stall <= 1'b1;
        else if (quiet)
            field_stall <= 1'b0;
        else
            field_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end

    always
    begin
        @(hold_request);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    task automatic send_item(input logic is_end, input logic [31:0] cp);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        mode       <= is_end;
        code_point <= cp;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        predict_fields(is_end, cp);
        items_sent++;
    endtask

    // Wait until every predicted field is out, then let the pipe settle
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (field_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_ext_wide(input logic value);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_wide  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        wide_sel = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_char();
        logic [31:0] cp;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                case ($urandom_range(0, 3))
                    0:       cp = CP_BLANK;
                    1:       cp = CP_LF;
                    2:       cp = CP_CR;
                    default: cp = CP_TAB;
                endcase
            end
            2, 3:    cp = $urandom_range(DIGIT_HI, DIGIT_LO);
            4, 5:    cp = $urandom_range(LETTER_HI, LETTER_LO);
            6:       cp = $urandom_range(255, 1);
            7:       cp = $urandom_range(32'h0000_FFFF, 32'h0000_0100);
            8:       cp = $urandom_range(32'h00FF_FFFF, 32'h0001_0000);
            default: cp = $urandom();
        endcase
        return cp;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Narrow mode: every class, boundaries, both kinds of end
    task automatic test_narrow_codes();
        write_ext_wide(1'b0);
        send_item(1'b1, 32'd0);          // empty string
        send_item(1'b0, CP_BLANK);
        send_item(1'b0, CP_LF);
        send_item(1'b0, CP_CR);
        send_item(1'b0, CP_TAB);
        send_item(1'b1, 32'hFFFF_FFFF);  // end from space run, code point ignored
        send_item(1'b0, DIGIT_LO);
        send_item(1'b0, DIGIT_HI);
        send_item(1'b0, LETTER_LO);
        send_item(1'b0, LETTER_HI);
        send_item(1'b0, 32'd42);
        send_item(1'b0, 32'd123);
        send_item(1'b0, LIM_8);
        send_item(1'b0, LIM_8 + 32'd1);
        send_item(1'b0, 32'hFFFF_FFFF);  // truncated to 16 bits
        send_item(1'b0, 32'd0);          // zero code point ends the string
        strings_sent += 3;
        drain();
    endtask

    // Wide mode: each length tag
    task automatic test_wide_extended();
        write_ext_wide(1'b1);
        send_item(1'b0, 32'h0000_007F);
        send_item(1'b0, LIM_16);
        send_item(1'b0, LIM_24);
        send_item(1'b0, LIM_24 + 32'd1);
        send_item(1'b1, 32'd0);
        strings_sent++;
        drain();
    endtask

    // Width flips while an extended run stays open
    task automatic test_width_switch();
        write_ext_wide(1'b1);
        send_item(1'b0, 32'h0000_03A0);
        write_ext_wide(1'b0);
        send_item(1'b0, 32'h0000_03A1);
        write_ext_wide(1'b1);
        send_item(1'b0, 32'h0000_007E);
        send_item(1'b1, 32'h1234_5678);
        strings_sent++;
        drain();
    endtask

    // Random strings; some left unterminated, width changed between them
    task automatic test_random_strings();
        int count;
        int len;
        int pick;
        count = 0;
        while (count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                write_ext_wide(1'($urandom_range(0, 1)));
            quiet = (strings_sent >= 10 && strings_sent < 14);
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++)
            begin
                send_item(1'b0, pick_char());
                count++;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                send_item(1'b1, $urandom());
                count++;
            end
            else if (pick < 8)
            begin
                send_item(1'b0, 32'd0);
                count++;
            end
            strings_sent++;
        end
        quiet = 1'b0;
        drain();
    endtask

    // Output held off while items keep coming, so the input stalls
    task automatic test_output_hold();
        write_ext_wide(1'b0);
        -> hold_request;
        for (int i = 0; i < 16; i++)
            send_item(1'b0, pick_char());
        send_item(1'b1, 32'd0);
        strings_sent++;
        drain();
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_narrow_codes();
        test_wide_extended();
        test_width_switch();
        test_random_strings();
        test_output_hold();

        drain();
        $display("sent %0d items in %0d strings, checked %0d fields", items_sent,
                 strings_sent, fields_seen);
        $display("both extended widths, width switches mid-run, %0d-cycle output hold",
                 HOLD_CYCLES);
        if (mismatches == 0 && field_queue.size() == 0)
            $display("[text_bitstream_string_encoder] OK");
        else
            $display("[text_bitstream_string_encoder] ERROR");
        $finish;
    end

endmodule
